@@ rtl/pts_pkg.sv @@
// shared types and constants of the periodic task scheduler
package pts_pkg;

    // default number of task slots
    localparam int TASK_SLOTS_DEF = 8;

    // most fire results one process request may give
    localparam int MAX_FIRES = 8;

    // command codes as they arrive on the action field
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_PROCESS  = 2'd1,
        OP_REGISTER = 2'd2,
        OP_TRIGGER  = 2'd3
    } op_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_FIRED      = 3'd0,
        KIND_REGISTERED = 3'd1,
        KIND_NONE_DUE   = 3'd2,
        KIND_TICK       = 3'd3,
        KIND_ERROR      = 3'd4
    } kind_t;

    // execution engine states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // classified command held between front and back
    typedef struct packed {
        op_t         op;
        logic [2:0]  sel;
        logic [15:0] period;
    } cmd_t;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  slot;
        logic [31:0] uptime;
        logic        last;
    } res_t;

endpackage

@@ rtl/pts_cmd_queue.sv @@
// front end: accepts requests, classifies the action and queues commands
module pts_cmd_queue
    import pts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [2:0]  slot_select,
    input  logic [15:0] period_ms,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    cmd_t       entry_reg [2];
    cmd_t       wr_cmd;
    logic       do_wr, do_rd;

    // classify the incoming request
    always_comb
    begin
        wr_cmd.op     = op_t'(action);
        wr_cmd.sel    = slot_select;
        wr_cmd.period = period_ms;
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_wr     = push && !full;
    assign do_rd     = cmd_pop && cmd_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

@@ rtl/pts_exec.sv @@
// back end: keeps uptime and slot tables and carries out queued commands
module pts_exec
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic res_push,
    output res_t res,
    input  logic res_full
);

    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int FW = $clog2(MAX_FIRES + 1);

    state_t        state_reg, state_next;
    logic [31:0]   elapsed_reg, elapsed_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [FW-1:0] nfire_reg, nfire_next;
    logic          hold_valid_reg, hold_valid_next;
    logic [2:0]    hold_slot_reg, hold_slot_next;
    logic [15:0]   cnt_reg [TASK_SLOTS];
    logic [15:0]   cnt_next [TASK_SLOTS];
    logic [15:0]   per_reg [TASK_SLOTS];
    logic          per_we;
    logic [SW-1:0] per_waddr;
    logic [15:0]   per_wdata;
    logic          scan_end;
    logic          due;

    // scan bookkeeping
    assign scan_end = (idx_reg == used_reg) || (nfire_reg == FW'(MAX_FIRES));
    assign due      = !scan_end && (cnt_reg[idx_reg[SW-1:0]] >= per_reg[idx_reg[SW-1:0]]);

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        elapsed_next    = elapsed_reg;
        used_next       = used_reg;
        idx_next        = idx_reg;
        nfire_next      = nfire_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        cnt_next        = cnt_reg;
        per_we          = 1'b0;
        per_waddr       = used_reg[SW-1:0];
        per_wdata       = cmd.period;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res.kind        = KIND_ERROR;
        res.slot        = 3'd0;
        res.uptime      = elapsed_reg;
        res.last        = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_TICK:
                        begin
                            elapsed_next = elapsed_reg + 32'd1;
                            for (int i = 0; i < TASK_SLOTS; i++)
                            begin
                                if ((CW'(i) < used_reg) && (cnt_reg[i] != 16'hFFFF))
                                begin
                                    cnt_next[i] = cnt_reg[i] + 16'd1;
                                end
                            end
                            res_push   = 1'b1;
                            res.kind   = KIND_TICK;
                            res.uptime = elapsed_next;
                        end
                        OP_PROCESS:
                        begin
                            state_next      = ST_SCAN;
                            idx_next        = '0;
                            nfire_next      = '0;
                            hold_valid_next = 1'b0;
                        end
                        OP_REGISTER:
                        begin
                            res_push = 1'b1;
                            if (used_reg != CW'(TASK_SLOTS))
                            begin
                                per_we                    = 1'b1;
                                cnt_next[used_reg[SW-1:0]] = 16'd0;
                                used_next                 = used_reg + CW'(1);
                                res.kind                  = KIND_REGISTERED;
                                res.slot                  = 3'(used_reg);
                            end
                        end
                        OP_TRIGGER:
                        begin
                            res_push = 1'b1;
                            if (32'(cmd.sel) < 32'(used_reg))
                            begin
                                cnt_next[SW'(cmd.sel)] = 16'd0;
                                res.kind               = KIND_FIRED;
                                res.slot               = cmd.sel;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    // close the run with the held fire or a nothing-due result
                    if (!res_full)
                    begin
                        res_push   = 1'b1;
                        state_next = ST_IDLE;
                        if (hold_valid_reg)
                        begin
                            res.kind = KIND_FIRED;
                            res.slot = hold_slot_reg;
                        end
                        else
                        begin
                            res.kind = KIND_NONE_DUE;
                        end
                    end
                end
                else if (due)
                begin
                    // a fire is held one step so the last one can be marked
                    if (!hold_valid_reg || !res_full)
                    begin
                        res_push                  = hold_valid_reg;
                        res.kind                  = KIND_FIRED;
                        res.slot                  = hold_slot_reg;
                        res.last                  = 1'b0;
                        hold_valid_next           = 1'b1;
                        hold_slot_next            = 3'(idx_reg);
                        cnt_next[idx_reg[SW-1:0]] = 16'd0;
                        nfire_next                = nfire_reg + FW'(1);
                        idx_next                  = idx_reg + CW'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            elapsed_reg    <= 32'd0;
            used_reg       <= '0;
            idx_reg        <= '0;
            nfire_reg      <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            elapsed_reg    <= elapsed_next;
            used_reg       <= used_next;
            idx_reg        <= idx_next;
            nfire_reg      <= nfire_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // slot tables, cleared by registration before first use
    always_ff @(posedge clk)
    begin
        hold_slot_reg <= hold_slot_next;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            cnt_reg[i] <= cnt_next[i];
        end
        if (per_we)
        begin
            per_reg[per_waddr] <= per_wdata;
        end
    end

endmodule

@@ rtl/pts_res_queue.sv @@
// result queue between the engine and the result port
module pts_res_queue
    import pts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    input  res_t res,
    output logic res_full,
    output logic empty,
    input  logic pop,
    output res_t head
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    res_t       entry_reg [2];
    logic       do_wr, do_rd;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = entry_reg[rd_ptr_reg];
    assign do_wr    = res_push && !res_full;
    assign do_rd    = pop && !empty;

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

@@ rtl/periodic_task_scheduler.sv @@
// top level of the periodic task scheduler
//
// requests enter through a queue port: push with action, slot_select and
// period_ms; a request is taken when push is high and full is low
// results leave through a queue port: the oldest result sits on result_kind,
// slot, uptime_ms and last_of_run while empty is low, and is taken on pop
// a two-entry command queue decouples the request side from the engine, and
// a two-entry result queue decouples the engine from the result side
// tick, register and trigger each give one result, pushed by the engine
// as it takes the command from the command queue
// process starts a scan of the registered slots, one slot per cycle unless a
// fire must wait for room in the result queue, and then closes the run with a
// last result; the scan stops early once eight slots have fired
// when the receiver stalls, results fill the result queue, the engine waits,
// then the command queue fills and full rises; nothing is dropped
// reset clears uptime, the slot count and both queues
module periodic_task_scheduler
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [2:0]  slot_select,
    input  logic [15:0] period_ms,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [2:0]  slot,
    output logic [31:0] uptime_ms,
    output logic        last_of_run
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic res_push;
    res_t res;
    logic res_full;
    res_t head;

    pts_cmd_queue u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .slot_select (slot_select),
        .period_ms   (period_ms),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    pts_exec #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    pts_res_queue u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    // result fields
    assign result_kind = head.kind;
    assign slot        = head.slot;
    assign uptime_ms   = head.uptime;
    assign last_of_run = head.last;

    // engine never writes into a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result written into full queue");

    // a command is taken only when its first result has room
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> (cmd_valid && !res_full))
        else $error("command taken without result room");

    // every kind other than fired ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res.kind != KIND_FIRED)) |-> res.last)
        else $error("non-fire result without run end");

endmodule
